>>> sv/poisson_binomial_pmf_convolver_core_assert.svh
// Assertion macros for the checker file of the pmf convolver.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef POISSON_BINOMIAL_PMF_CONVOLVER_CORE_ASSERT_SVH
`define POISSON_BINOMIAL_PMF_CONVOLVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PBC_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBC_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared constants and types of the Poisson binomial pmf convolver.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned MAX_TRIALS  = 1024;
  localparam int unsigned STORE_DEPTH = MAX_TRIALS + 1;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned DATA_W      = FRAC_W + 1;
  localparam int unsigned PROD_W      = 2 * FRAC_W;

  localparam logic [DATA_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};

  // Command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FOLD  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  // Tag that travels with one entry through the fold sweep.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } sweep_t;

endpackage

>>> sv/poisson_binomial_pmf_convolver_core.sv
// ----------------------------------------------------------------------------
// poisson_binomial_pmf_convolver_core
// Poisson binomial pmf builder: start, fold and read over one entry RAM.
// ----------------------------------------------------------------------------
// Start answers via ST_START0 and ST_START1, read via ST_READ, a fold with L
// stored entries via ST_FOLD; full fold, bad read and no-op from ST_IDLE.
// A fold sweeps entries 0..L through the single RAM read port, one a cycle.
// busy is high outside ST_IDLE and low in the result cycle; the next command can be
// accepted in the cycle that carries the result. The result cannot be stalled.
// Reset empties the pmf (entry count zero); RAM contents are not cleared.
module poisson_binomial_pmf_convolver_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command_i,
  input  logic [pbc_pkg::DATA_W-1:0] probability_i,
  input  logic [pbc_pkg::CNT_W-1:0]  read_index_i,
  output logic                       valid_o,
  output logic [pbc_pkg::DATA_W-1:0] pmf_value_o,
  output logic [pbc_pkg::CNT_W-1:0]  entry_count_o,
  output logic [1:0]                 status_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START0,
    ST_START1,
    ST_FOLD,
    ST_READ
  } state_e;

  localparam logic [pbc_pkg::CNT_W-1:0] START_LEN = pbc_pkg::CNT_W'(2);

  state_e                       state_q;
  logic [pbc_pkg::CNT_W-1:0]    len_q;
  logic [pbc_pkg::DATA_W-1:0]   p_q;
  logic [pbc_pkg::DATA_W-1:0]   q_q;
  logic [pbc_pkg::ADDR_W-1:0]   rd_j_q;
  logic                         issue_q;
  pbc_pkg::sweep_t              s1_q;
  logic                         valid_q;
  logic [pbc_pkg::DATA_W-1:0]   value_q;
  logic [pbc_pkg::CNT_W-1:0]    count_q;
  logic [1:0]                   status_q;

  logic                         accept;
  logic [pbc_pkg::DATA_W-1:0]   p_sat;
  logic [pbc_pkg::DATA_W-1:0]   q_sat;
  logic                         ram_we;
  logic [pbc_pkg::ADDR_W-1:0]   ram_waddr;
  logic [pbc_pkg::DATA_W-1:0]   ram_wdata;
  logic [pbc_pkg::ADDR_W-1:0]   ram_raddr;
  logic [pbc_pkg::DATA_W-1:0]   ram_rdata;
  pbc_pkg::sweep_t              s2_tag;
  logic [pbc_pkg::DATA_W-1:0]   s2_sum;
  logic                         fold_go;

  assign accept  = start && !busy;
  assign p_sat   = probability_i[pbc_pkg::FRAC_W] ? pbc_pkg::Q_ONE : probability_i;
  assign q_sat   = pbc_pkg::Q_ONE - p_sat;
  assign fold_go = accept && (command_i == pbc_pkg::CMD_FOLD) && (len_q >= START_LEN) &&
                   (len_q != pbc_pkg::CNT_W'(pbc_pkg::STORE_DEPTH));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = s2_sum;
    ram_raddr = rd_j_q;
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = read_index_i[pbc_pkg::ADDR_W-1:0];
      end
      ST_START0: begin
        ram_we    = 1'b1;
        ram_wdata = q_q;
      end
      ST_START1: begin
        ram_we    = 1'b1;
        ram_waddr = pbc_pkg::ADDR_W'(1);
        ram_wdata = p_q;
      end
      ST_FOLD: begin
        ram_we    = s2_tag.vld;
        ram_waddr = s2_tag.idx;
      end
      ST_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      issue_q  <= 1'b0;
      s1_q     <= '0;
      valid_q  <= 1'b0;
      value_q  <= '0;
      count_q  <= '0;
      status_q <= pbc_pkg::STAT_OK;
      p_q      <= '0;
      q_q      <= '0;
      rd_j_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      s1_q    <= '0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            p_q     <= p_sat;
            q_q     <= q_sat;
            rd_j_q  <= '0;
            value_q <= '0;
            count_q <= len_q;
            priority if (command_i == pbc_pkg::CMD_START ||
                         (command_i == pbc_pkg::CMD_FOLD && len_q < START_LEN)) begin
              state_q <= ST_START0;
            end else if (fold_go) begin
              state_q <= ST_FOLD;
              issue_q <= 1'b1;
            end else if (command_i == pbc_pkg::CMD_FOLD) begin
              valid_q  <= 1'b1;
              status_q <= pbc_pkg::STAT_FULL;
            end else if (command_i == pbc_pkg::CMD_READ && read_index_i < len_q) begin
              state_q <= ST_READ;
            end else if (command_i == pbc_pkg::CMD_READ) begin
              valid_q  <= 1'b1;
              status_q <= pbc_pkg::STAT_BAD_INDEX;
            end else begin
              valid_q  <= 1'b1;
              status_q <= pbc_pkg::STAT_OK;
            end
          end
        end
        ST_START0: begin
          state_q <= ST_START1;
        end
        ST_START1: begin
          state_q  <= ST_IDLE;
          len_q    <= START_LEN;
          valid_q  <= 1'b1;
          value_q  <= '0;
          count_q  <= START_LEN;
          status_q <= pbc_pkg::STAT_OK;
        end
        ST_FOLD: begin
          // Reads run ahead of write-back by the RAM read register and the product
          // registers, so no entry is read after its new value has been written.
          if (issue_q) begin
            s1_q.vld  <= 1'b1;
            s1_q.last <= (pbc_pkg::CNT_W'(rd_j_q) == len_q);
            s1_q.idx  <= rd_j_q;
            rd_j_q    <= rd_j_q + pbc_pkg::ADDR_W'(1);
            if (pbc_pkg::CNT_W'(rd_j_q) == len_q) begin
              issue_q <= 1'b0;
            end
          end
          if (s2_tag.vld && s2_tag.last) begin
            state_q  <= ST_IDLE;
            len_q    <= len_q + pbc_pkg::CNT_W'(1);
            valid_q  <= 1'b1;
            value_q  <= '0;
            count_q  <= len_q + pbc_pkg::CNT_W'(1);
            status_q <= pbc_pkg::STAT_OK;
          end
        end
        ST_READ: begin
          state_q  <= ST_IDLE;
          valid_q  <= 1'b1;
          value_q  <= ram_rdata;
          count_q  <= len_q;
          status_q <= pbc_pkg::STAT_OK;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  pbc_ram #(
    .WIDTH(pbc_pkg::DATA_W),
    .DEPTH(pbc_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pbc_fold_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .clr_i (fold_go),
    .tag_i (s1_q),
    .cur_i (ram_rdata),
    .p_i   (p_q),
    .q_i   (q_q),
    .tag_o (s2_tag),
    .sum_o (s2_sum)
  );

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign pmf_value_o   = value_q;
  assign entry_count_o = count_q;
  assign status_o      = status_q;

endmodule

>>> sv/pbc_ram.sv
// ----------------------------------------------------------------------------
// pbc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pbc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pbc_fold_dp.sv
// ----------------------------------------------------------------------------
// pbc_fold_dp
// Multiply-add datapath of the fold sweep: registered products, then a combinational sum.
// ----------------------------------------------------------------------------
module pbc_fold_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  pbc_pkg::sweep_t            tag_i,
  input  logic [pbc_pkg::DATA_W-1:0] cur_i,
  input  logic [pbc_pkg::DATA_W-1:0] p_i,
  input  logic [pbc_pkg::DATA_W-1:0] q_i,
  output pbc_pkg::sweep_t            tag_o,
  output logic [pbc_pkg::DATA_W-1:0] sum_o
);

  // Truncated Q1.32 product; an operand equal to one passes the other through.
  function automatic logic [pbc_pkg::DATA_W-1:0] qmul(
    input logic [pbc_pkg::DATA_W-1:0] a,
    input logic [pbc_pkg::DATA_W-1:0] b
  );
    logic [pbc_pkg::PROD_W-1:0] prod;
    prod = pbc_pkg::PROD_W'(a[pbc_pkg::FRAC_W-1:0]) *
           pbc_pkg::PROD_W'(b[pbc_pkg::FRAC_W-1:0]);
    if (a[pbc_pkg::FRAC_W]) begin
      return b;
    end else if (b[pbc_pkg::FRAC_W]) begin
      return a;
    end
    return {1'b0, prod[pbc_pkg::PROD_W-1:pbc_pkg::FRAC_W]};
  endfunction

  logic [pbc_pkg::DATA_W-1:0] cur;
  logic [pbc_pkg::DATA_W-1:0] prev_q;
  logic [pbc_pkg::DATA_W-1:0] prod_p_q;
  logic [pbc_pkg::DATA_W-1:0] prod_q_q;
  pbc_pkg::sweep_t            tag_q;

  // The entry one past the old end may hold stale data and counts as zero.
  assign cur = tag_i.last ? '0 : cur_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      prev_q <= '0;
    end else if (tag_i.vld) begin
      prev_q <= cur;
    end
    prod_p_q <= qmul(p_i, prev_q);
    prod_q_q <= qmul(q_i, cur);
  end

  assign tag_o = tag_q;
  assign sum_o = prod_p_q + prod_q_q;

endmodule

>>> sv/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks of the pmf convolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "poisson_binomial_pmf_convolver_core_assert.svh"

module pbc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 command_i,
  input logic                       valid_o,
  input logic [pbc_pkg::DATA_W-1:0] pmf_value_o,
  input logic [pbc_pkg::CNT_W-1:0]  entry_count_o,
  input logic [1:0]                 status_o
);

  // A failed beat never carries a value.
  `PBC_ASSERT_IMP(a_fail_zero, valid_o && status_o != pbc_pkg::STAT_OK, pmf_value_o == '0, "failed beat carries a value")
  // The result beat falls in a cycle in which a new command can be taken.
  `PBC_ASSERT_IMP(a_result_idle, valid_o, !busy, "result beat while busy")
  // Every accepted command either answers at once or keeps the block busy.
  `PBC_ASSERT_NXT(a_accept_progress, start && !busy, busy || valid_o, "accepted command dropped")
  // A start command answers with a two-entry pmf and status OK.
  `PBC_ASSERT_IMP(a_start_result, start && !busy && command_i == pbc_pkg::CMD_START, ##3 (valid_o && entry_count_o == pbc_pkg::CNT_W'(2) && status_o == pbc_pkg::STAT_OK), "start result wrong")
  // The entry count never exceeds the store depth.
  `PBC_ASSERT_IMP(a_count_range, valid_o, entry_count_o <= pbc_pkg::CNT_W'(pbc_pkg::STORE_DEPTH), "entry count out of range")

endmodule

bind poisson_binomial_pmf_convolver_core pbc_checker u_pbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .command_i    (command_i),
  .valid_o      (valid_o),
  .pmf_value_o  (pmf_value_o),
  .entry_count_o(entry_count_o),
  .status_o     (status_o)
);

>>> tb/poisson_binomial_pmf_convolver_checker.sv
// ----------------------------------------------------------------------------
// poisson_binomial_pmf_convolver_checker
// Watches the command and result beats of the pmf convolver, keeps its own
// copy of the pmf, works out each expected result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module poisson_binomial_pmf_convolver_checker
  import pbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        command_i,
  input  logic [DATA_W-1:0] probability_i,
  input  logic [CNT_W-1:0]  read_index_i,
  input  logic              valid_o,
  input  logic [DATA_W-1:0] pmf_value_o,
  input  logic [CNT_W-1:0]  entry_count_o,
  input  logic [1:0]        status_o,
  output int                errors_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [1:0]        status;
  } pmf_result_t;

  logic [DATA_W-1:0] pmf_copy [STORE_DEPTH];
  int                pmf_length = 0;
  pmf_result_t       pending_results [$];
  int                mismatches = 0;
  int                waiting = 0;

  assign errors_o      = mismatches;
  assign outstanding_o = waiting;

  // Truncated Q1.32 product; both operands are at most one.
  function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    return prod[FRAC_W+DATA_W-1:FRAC_W];
  endfunction

  // Applies one command to the local pmf and returns the result it should give.
  function automatic pmf_result_t apply_command(logic [1:0] cmd, logic [DATA_W-1:0] prob,
                                                logic [CNT_W-1:0] idx);
    pmf_result_t       res;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] cur;
    int                len;
    res = '0;
    p = (prob > Q_ONE) ? Q_ONE : prob;
    q = Q_ONE - p;
    if (cmd == CMD_START || (cmd == CMD_FOLD && pmf_length < 2)) begin
      // A fold into the empty pmf is the same as starting from that trial.
      pmf_copy[0] = q;
      pmf_copy[1] = p;
      pmf_length  = 2;
    end else if (cmd == CMD_FOLD) begin
      if (pmf_length >= STORE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        len = pmf_length;
        prev = pmf_copy[0];
        pmf_copy[len] = q_mul(p, pmf_copy[len-1]);
        pmf_copy[0]   = q_mul(q, prev);
        for (int j = 1; j < len; j++) begin
          cur = pmf_copy[j];
          pmf_copy[j] = q_mul(p, prev) + q_mul(q, cur);
          prev = cur;
        end
        pmf_length = len + 1;
      end
    end else if (cmd == CMD_READ) begin
      if (int'(idx) < pmf_length) begin
        res.value = pmf_copy[idx];
      end else begin
        res.status = STAT_BAD_INDEX;
      end
    end
    res.count = pmf_length[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin : watch_beats
    pmf_result_t want;
    pmf_result_t got;
    if (rst_ni) begin
      if (valid_o) begin
        got = {pmf_value_o, entry_count_o, status_o};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected: value %h count %0d status %0d",
                   $time, got.value, got.count, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            mismatches++;
            $display("%0t: pmf_value expected %h actual %h", $time, want.value, got.value);
          end
          if (got.count !== want.count) begin
            mismatches++;
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
          end
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_command(command_i, probability_i, read_index_i));
      end
      waiting = pending_results.size();
    end
  end

endmodule

>>> tb/poisson_binomial_pmf_convolver_core_tb.sv
// ----------------------------------------------------------------------------
// poisson_binomial_pmf_convolver_core_tb
// Drives start, fold, read and unused commands into the pmf convolver with
// random gaps, and reports the verdict of the checker that sits beside the
// block.
// ----------------------------------------------------------------------------
module poisson_binomial_pmf_convolver_core_tb;
  import pbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_ITEMS  = 540;
  localparam int RANDOM_MAXLEN = 48;
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command_i = CMD_START;
  logic [DATA_W-1:0] probability_i = '0;
  logic [CNT_W-1:0]  read_index_i = '0;
  logic              valid_o;
  logic [DATA_W-1:0] pmf_value_o;
  logic [CNT_W-1:0]  entry_count_o;
  logic [1:0]        status_o;
  int                errors;
  int                outstanding;
  int                cycles = 0;
  int                shadow_length = 0;
  bit                gaps_on = 1'b1;

  always #2 clk_i = ~clk_i;

  poisson_binomial_pmf_convolver_core dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .probability_i, .read_index_i,
    .valid_o, .pmf_value_o, .entry_count_o, .status_o
  );

  poisson_binomial_pmf_convolver_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .command_i, .probability_i, .read_index_i,
    .valid_o, .pmf_value_o, .entry_count_o, .status_o,
    .errors_o(errors), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly legal probabilities, with the edges and saturating values mixed in.
  function automatic logic [DATA_W-1:0] draw_probability();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return Q_ONE;
    if (pick == 2) return {1'b1, 32'($urandom())};
    return {1'b0, 32'($urandom())};
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_command(logic [1:0] cmd, logic [DATA_W-1:0] prob, logic [CNT_W-1:0] idx);
    int gap;
    gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    probability_i <= prob;
    read_index_i  <= idx;
    do @(posedge clk_i); while (busy);
    if (cmd == CMD_START || (cmd == CMD_FOLD && shadow_length < 2)) begin
      shadow_length = 2;
    end else if (cmd == CMD_FOLD && shadow_length < STORE_DEPTH) begin
      shadow_length++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int counted;
    int pick;
    logic [CNT_W-1:0] idx;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty store, edge probabilities, saturation and bad indexes.
    send_command(CMD_READ, '0, '0);
    send_command(CMD_FOLD, {1'b0, 32'h4CCC_CCCD}, '0);
    send_command(CMD_NOP, {DATA_W{1'b1}}, {CNT_W{1'b1}});
    send_command(CMD_START, '0, '0);
    send_command(CMD_START, Q_ONE, '0);
    send_command(CMD_START, {DATA_W{1'b1}}, '0);
    send_command(CMD_READ, '0, 11'd1);
    send_command(CMD_FOLD, Q_ONE, '0);
    send_command(CMD_FOLD, '0, '0);
    send_command(CMD_FOLD, {1'b0, 32'h8000_0000}, '0);
    send_command(CMD_FOLD, {1'b0, 32'hFFFF_FFFF}, '0);
    send_command(CMD_FOLD, {1'b0, 32'h0000_0001}, '0);
    for (int i = 0; i <= shadow_length; i++) begin
      send_command(CMD_READ, '0, CNT_W'(i));
    end
    send_command(CMD_READ, '0, {CNT_W{1'b1}});
    drain();

    // Random: short pmfs built and read back, with some noise commands.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (counted == RANDOM_ITEMS / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_command(CMD_NOP, draw_probability(), CNT_W'($urandom()));
      end else if (pick < 14 || (pick < 55 && shadow_length >= RANDOM_MAXLEN)) begin
        send_command(CMD_START, draw_probability(), CNT_W'($urandom()));
        counted++;
      end else if (pick < 55) begin
        send_command(CMD_FOLD, draw_probability(), CNT_W'($urandom()));
        counted++;
      end else begin
        if (pick < 88 && shadow_length > 0) begin
          idx = CNT_W'($urandom_range(0, shadow_length - 1));
        end else begin
          idx = CNT_W'($urandom());
        end
        send_command(CMD_READ, draw_probability(), idx);
        counted++;
      end
    end
    drain();

    repeat (16) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/pbc_pkg.sv
sv/pbc_ram.sv
sv/pbc_fold_dp.sv
sv/poisson_binomial_pmf_convolver_core.sv
sv/pbc_checker.sv
tb/poisson_binomial_pmf_convolver_checker.sv
tb/poisson_binomial_pmf_convolver_core_tb.sv
